/* rtl/rswr_pkg.sv */
package rswr_pkg;

  localparam int WORD_W   = 31;
  localparam int CFG_W    = 9;
  localparam int VALUE_W  = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 2'd1;

  // commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PICKED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_FILL,
    S_DRAW,
    S_DIV,
    S_RD,
    S_EVAL,
    S_CMP_RD,
    S_CMP_WR
  } state_e;

endpackage

/* rtl/rswr_ram.sv */
module rswr_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rswr_div.sv */
// Restoring remainder unit: one dividend bit per cycle.
module rswr_div
  import rswr_pkg::*;
#(
  parameter int DIVISOR_W = 9,
  parameter int REM_W     = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_W-1:0]    dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [REM_W-1:0]     rem_o
);

  localparam int CNT_W = $clog2(WORD_W);

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIVISOR_W-1:0] rem_q, div_q;
  logic [WORD_W-1:0]    dvd_q;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  assign trial = {rem_q, dvd_q[WORD_W-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit drops
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[REM_W-1:0];

endmodule

/* rtl/random_sample_without_replacement.sv */
// Random sampling without replacement.
// Input channel: in_valid_i / in_stall_o carries command_i (start or draw) and
// random_word_i. Output channel: out_valid_o / out_stall_i carries
// picked_value_o, status_o and last_o. Config registers (pool size, pick
// count) are written through cfg_we_i / cfg_addr_i / cfg_wdata_i only while
// idle; the user must keep to this, as the block itself does not enforce it.
// One request is handled at a time; in_stall_o is high while one is at work.
// A draw that reaches the pool goes through accept, launch, the remainder
// steps (one per random word bit), pick up the remainder, pool read and
// evaluate. A draw with no active run or an empty pool is answered from
// the launch state without the remainder unit.
// A start that is not rejected fills the pool memory in one sweep.
// A failed draw that triggers compaction then reads every live pool entry
// and conditionally writes it back to the front, ending with a final end check.
// A result sits in an output register; the block goes on taking requests
// while it waits, and only holds when a second result is ready while the
// receiver still stalls the first.
// Reset clears the counters and leaves no run active; pool memory contents
// are undefined until a start fills them.
module random_sample_without_replacement
  import rswr_pkg::*;
#(
  parameter int POOL_MAX = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [WORD_W-1:0]    random_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VALUE_W-1:0]   picked_value_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 last_o
);

  localparam int LW = $clog2(POOL_MAX + 1);
  localparam int AW = $clog2(POOL_MAX);

  state_e state_q, state_d;

  logic [CFG_W-1:0] pool_size_q, pick_count_q;
  logic [WORD_W-1:0] word_q;
  logic [LW-1:0] live_q, live_d;
  logic [LW:0]   failed_q, failed_d;
  logic [CFG_W-1:0] picks_q, picks_d;
  logic active_q, active_d;
  logic [LW-1:0] idx_q, idx_d, keep_q, keep_d;
  logic [AW-1:0] slot_q, slot_d;

  logic out_valid_q;
  logic [VALUE_W-1:0]  value_q;
  logic [STATUS_W-1:0] status_q;
  logic last_q;

  logic emit, emit_last, out_free;
  logic [STATUS_W-1:0] emit_status;
  logic [VALUE_W-1:0]  emit_value;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [AW:0]   ram_wdata, ram_rdata;

  logic div_start, div_done;
  logic [AW-1:0] div_rem;

  logic [LW-1:0] size_sat;
  logic [LW:0]   failed_inc, live_plus1;
  logic [CFG_W-1:0] picks_inc;
  logic pick_last;

  assign size_sat   = (32'(pool_size_q) > POOL_MAX) ? LW'(POOL_MAX) : LW'(pool_size_q);
  assign failed_inc = failed_q + (LW+1)'(1);
  assign live_plus1 = {1'b0, live_q} + (LW+1)'(1);
  assign picks_inc  = picks_q + CFG_W'(1);
  assign pick_last  = picks_inc >= pick_count_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  rswr_ram #(
    .WIDTH(AW + 1),
    .DEPTH(POOL_MAX)
  ) u_pool (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rswr_div #(
    .DIVISOR_W(LW),
    .REM_W    (AW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(word_q),
    .divisor_i (live_q),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q  <= CFG_W'(16);
      pick_count_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_POOL_SIZE:  pool_size_q  <= cfg_wdata_i;
        REG_PICK_COUNT: pick_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      live_q   <= '0;
      failed_q <= '0;
      picks_q  <= '0;
      active_q <= 1'b0;
      idx_q    <= '0;
      keep_q   <= '0;
    end else begin
      state_q  <= state_d;
      live_q   <= live_d;
      failed_q <= failed_d;
      picks_q  <= picks_d;
      active_q <= active_d;
      idx_q    <= idx_d;
      keep_q   <= keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (state_q == S_IDLE && in_valid_i) begin
      word_q <= random_word_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    live_d      = live_q;
    failed_d    = failed_q;
    picks_d     = picks_q;
    active_d    = active_q;
    idx_d       = idx_q;
    keep_d      = keep_q;
    slot_d      = slot_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = slot_q;
    div_start   = 1'b0;
    emit        = 1'b0;
    emit_status = ST_PICKED;
    emit_value  = '0;
    emit_last   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (command_i == CMD_START) ? S_START : S_DRAW;
        end
      end
      S_START: begin
        active_d = 1'b0;
        if (32'(pick_count_q) > 32'(size_sat)) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_REJECT;
            state_d     = S_IDLE;
          end
        end else begin
          live_d   = size_sat;
          failed_d = '0;
          picks_d  = '0;
          idx_d    = '0;
          state_d  = S_FILL;
        end
      end
      S_FILL: begin
        if (idx_q < live_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[AW-1:0];
          ram_wdata = {1'b1, idx_q[AW-1:0]};
          idx_d     = idx_q + LW'(1);
        end else if (pick_count_q == '0) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_EMPTY;
            state_d     = S_IDLE;
          end
        end else begin
          active_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_DRAW: begin
        if (!active_q || live_q == '0) begin
          if (out_free) begin
            active_d    = 1'b0;
            emit        = 1'b1;
            emit_status = ST_EMPTY;
            state_d     = S_IDLE;
          end
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          slot_d  = div_rem;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (ram_rdata[AW]) begin
          if (out_free) begin
            ram_we     = 1'b1;
            ram_waddr  = slot_q;
            ram_wdata  = {1'b0, ram_rdata[AW-1:0]};
            failed_d   = '0;
            picks_d    = picks_inc;
            emit       = 1'b1;
            emit_value = VALUE_W'(ram_rdata[AW-1:0]);
            emit_last  = pick_last;
            active_d   = !pick_last;
            state_d    = S_IDLE;
          end
        end else if (failed_inc >= live_plus1) begin
          idx_d   = '0;
          keep_d  = '0;
          state_d = S_CMP_RD;
        end else begin
          failed_d = failed_inc;
          state_d  = S_IDLE;
        end
      end
      S_CMP_RD: begin
        ram_raddr = idx_q[AW-1:0];
        if (idx_q == live_q) begin
          live_d   = keep_q;
          failed_d = '0;
          state_d  = S_IDLE;
        end else begin
          state_d = S_CMP_WR;
        end
      end
      S_CMP_WR: begin
        ram_raddr = idx_q[AW-1:0];
        // unused entries slide down to the front, order kept
        if (ram_rdata[AW]) begin
          ram_we    = 1'b1;
          ram_waddr = keep_q[AW-1:0];
          ram_wdata = ram_rdata;
          keep_d    = keep_q + LW'(1);
        end
        idx_d   = idx_q + LW'(1);
        state_d = S_CMP_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q  <= emit_value;
      status_q <= emit_status;
      last_q   <= emit_last;
    end
  end

  assign in_stall_o     = state_q != S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign picked_value_o = value_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

endmodule

/* test/random_sample_without_replacement_tb.sv */
`timescale 1ns / 100ps

module random_sample_without_replacement_tb;
  import rswr_pkg::*;

  localparam int POOL_MAX         = 256;
  localparam int SETTLE_CYCLES    = 2 * POOL_MAX + 100;
  localparam int QUIET_LIMIT      = 8000;
  localparam int RANDOM_REQUESTS  = 850;
  localparam int POOL_SIZE_RESET  = 16;
  localparam int PICK_COUNT_RESET = 1;
  localparam int MAX_REPORTS      = 10;

  // indexes past the register file, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [WORD_W-1:0]    WORD_MAX    = '1;
  localparam logic [CFG_W-1:0]     CFG_MAX     = '1;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                last;
  } pick_result_t;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic                 cmd;
    logic [WORD_W-1:0]    word;
    logic                 typed;
    pick_result_t         want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 command = CMD_START;
  logic [WORD_W-1:0]    random_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VALUE_W-1:0]   picked_value;
  logic [STATUS_W-1:0]  pick_status;
  logic                 pick_last;

  random_sample_without_replacement #(
    .POOL_MAX(POOL_MAX)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .random_word_i (random_word),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .picked_value_o(picked_value),
    .status_o      (pick_status),
    .last_o        (pick_last)
  );

  // sampler state as the block should hold it
  logic [CFG_W-1:0] cfg_pool_size;
  logic [CFG_W-1:0] cfg_pick_count;
  logic [CFG_W-1:0] pool_entry [POOL_MAX];
  logic             entry_free [POOL_MAX];
  int unsigned      live_count;
  int unsigned      miss_run;
  int unsigned      picks_made;
  logic             run_open;

  pick_result_t pending_picks [$];
  script_row_t  script [$];
  logic         block_dirty = 1'b0;

  int fault_count    = 0;
  int quiet_cycles   = 0;
  int requests_sent  = 0;
  int starts_sent    = 0;
  int results_seen   = 0;
  int picks_seen     = 0;
  int rejects_seen   = 0;
  int empties_seen   = 0;
  int compactions    = 0;
  int reg_writes     = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic pick_result_t result_of(logic [VALUE_W-1:0] value,
                                             logic [STATUS_W-1:0] status, logic last);
    pick_result_t res;
    res.value  = value;
    res.status = status;
    res.last   = last;
    return res;
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    script_row_t row;
    row         = '0;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = data;
    script.insert(script.size(), row);
  endfunction

  function automatic void add_request(logic cmd, logic [WORD_W-1:0] word,
                                      logic typed = 1'b0, pick_result_t want = '0);
    script_row_t row;
    row       = '0;
    row.kind  = ROW_REQUEST;
    row.cmd   = cmd;
    row.word  = word;
    row.typed = typed;
    row.want  = want;
    script.insert(script.size(), row);
  endfunction

  // Returns 1 when the request yields a result, which lands in res.
  function automatic logic predict_sampler(input logic cmd, input logic [WORD_W-1:0] word,
                                           output pick_result_t res);
    int unsigned size;
    int unsigned slot;
    int unsigned keep;
    res = '0;
    if (cmd == CMD_START) begin
      size = (cfg_pool_size > POOL_MAX) ? POOL_MAX : cfg_pool_size;
      run_open = 1'b0;
      if (cfg_pick_count > size) begin
        res.status = ST_REJECT;
        return 1'b1;
      end
      for (int i = 0; i < size; i++) begin
        pool_entry[i] = CFG_W'(i);
        entry_free[i] = 1'b1;
      end
      live_count = size;
      miss_run   = 0;
      picks_made = 0;
      if (cfg_pick_count == 0) begin
        res.status = ST_EMPTY;
        return 1'b1;
      end
      run_open = 1'b1;
      return 1'b0;
    end
    if (!run_open) begin
      res.status = ST_EMPTY;
      return 1'b1;
    end
    if (live_count == 0) begin
      run_open   = 1'b0;
      res.status = ST_EMPTY;
      return 1'b1;
    end
    slot = word % live_count;
    if (entry_free[slot]) begin
      entry_free[slot] = 1'b0;
      miss_run   = 0;
      picks_made++;
      res.value  = pool_entry[slot][VALUE_W-1:0];
      res.status = ST_PICKED;
      res.last   = (picks_made >= cfg_pick_count);
      if (res.last) run_open = 1'b0;
      return 1'b1;
    end
    miss_run++;
    if (miss_run >= live_count + 1) begin
      // squeeze unused entries to the front, order kept
      keep = 0;
      for (int i = 0; i < live_count; i++) begin
        if (entry_free[i]) begin
          pool_entry[keep] = pool_entry[i];
          entry_free[keep] = 1'b1;
          keep++;
        end
      end
      for (int i = keep; i < live_count; i++) entry_free[i] = 1'b0;
      live_count = keep;
      miss_run   = 0;
      compactions++;
    end
    return 1'b0;
  endfunction

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic send_request(input logic cmd, input logic [WORD_W-1:0] word,
                              input logic burst, input logic typed = 1'b0,
                              input pick_result_t want = '0);
    int unsigned  roll;
    int unsigned  gap;
    pick_result_t res;
    logic         has_result;
    gap = 0;
    if (!burst) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) gap = 0;
      else if (roll < 88) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(30, 80);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid    = 1'b1;
    command     = cmd;
    random_word = word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has_result = predict_sampler(cmd, word, res);
    if (typed) pending_picks.insert(pending_picks.size(), want);
    else if (has_result) pending_picks.insert(pending_picks.size(), res);
    requests_sent++;
    if (cmd == CMD_START) starts_sent++;
    block_dirty = 1'b1;
  endtask

  // Hold off the sender until every owed result is out and the block is quiet.
  task automatic settle_block();
    if (!block_dirty) return;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    block_dirty = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = data;
    @(posedge clk);
    if (idx == REG_POOL_SIZE) cfg_pool_size = data;
    else if (idx == REG_PICK_COUNT) cfg_pick_count = data;
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] draw_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return WORD_W'($urandom());
    if (roll < 95) return WORD_W'($urandom_range(0, 63));
    return (roll < 98) ? WORD_MAX : '0;
  endfunction

  task automatic random_phase();
    int unsigned size_roll;
    int unsigned pick_roll;
    int unsigned pool_sz;
    int unsigned eff_size;
    int unsigned pick_cnt;
    int unsigned draws;
    logic        burst;
    burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) != 0) begin
      size_roll = $urandom_range(0, 99);
      if (size_roll < 4) pool_sz = 0;
      else if (size_roll < 8) pool_sz = $urandom_range(POOL_MAX + 1, 511);
      else if (size_roll < 14) pool_sz = POOL_MAX;
      else if (size_roll < 28) pool_sz = $urandom_range(17, 100);
      else pool_sz = $urandom_range(1, 16);
      eff_size = (pool_sz > POOL_MAX) ? POOL_MAX : pool_sz;
      pick_roll = $urandom_range(0, 99);
      if (pick_roll < 8) pick_cnt = 0;
      else if (pick_roll < 16) pick_cnt = $urandom_range(eff_size + 1, 511);
      else if (eff_size == 0) pick_cnt = $urandom_range(1, 3);
      else if (eff_size <= 16) pick_cnt = $urandom_range(1, eff_size);
      else pick_cnt = $urandom_range(1, 12);
      settle_block();
      case ($urandom_range(0, 9))
        0: write_reg(REG_PICK_COUNT, CFG_W'(pick_cnt));
        1: write_reg(REG_POOL_SIZE, CFG_W'(pool_sz));
        2: begin
          write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                    CFG_W'($urandom_range(0, 511)));
          write_reg(REG_POOL_SIZE, CFG_W'(pool_sz));
          write_reg(REG_PICK_COUNT, CFG_W'(pick_cnt));
        end
        default: begin
          write_reg(REG_POOL_SIZE, CFG_W'(pool_sz));
          write_reg(REG_PICK_COUNT, CFG_W'(pick_cnt));
        end
      endcase
    end
    // mostly a fresh run; sometimes keep drawing from the old one
    if ($urandom_range(0, 7) != 0) send_request(CMD_START, draw_word(), burst);
    draws = 0;
    while (run_open && draws < 400) begin
      if ($urandom_range(0, 49) == 0) send_request(CMD_START, draw_word(), burst);
      else send_request(CMD_DRAW, draw_word(), burst);
      draws++;
    end
    repeat ($urandom_range(0, 2)) send_request(CMD_DRAW, draw_word(), burst);
  endtask

  // receiver: short stalls mostly, a few long ones, some long open stretches
  initial begin
    int unsigned roll;
    int unsigned open_len;
    int unsigned hold_len;
    forever begin
      roll = $urandom_range(0, 99);
      open_len = (roll < 10) ? $urandom_range(100, 300) : $urandom_range(0, 4);
      roll = $urandom_range(0, 99);
      if (roll < 75) hold_len = $urandom_range(1, 3);
      else if (roll < 95) hold_len = $urandom_range(4, 12);
      else hold_len = $urandom_range(30, 70);
      repeat (open_len) begin
        @(negedge clk);
        out_stall = 1'b0;
      end
      repeat (hold_len) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pick_result_t seen;
    pick_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen = result_of(picked_value, pick_status, pick_last);
        results_seen++;
        quiet_cycles = 0;
        case (pick_status)
          ST_PICKED: picks_seen++;
          ST_REJECT: rejects_seen++;
          ST_EMPTY:  empties_seen++;
          default: ;
        endcase
        if (pending_picks.size() == 0) begin
          log_fault($sformatf("result %0d not expected: value %0d status %0d last %0d",
                              results_seen, seen.value, seen.status, seen.last));
        end else begin
          want = pending_picks.pop_front();
          if (seen !== want)
            log_fault($sformatf({"result %0d: expected value %0d status %0d last %0d,",
                                 " got value %0d status %0d last %0d"}, results_seen,
                                want.value, want.status, want.last,
                                seen.value, seen.status, seen.last));
        end
      end else if (in_valid && !in_stall) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no handshake for %0d cycles, %0d results owed",
                   quiet_cycles, pending_picks.size());
          $display("random_sample_without_replacement_tb NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    script_row_t row;
    int          random_base;

    // no run yet, then the reset setting of 16 entries and one pick
    add_request(CMD_DRAW, 31'd3, 1'b1, result_of(8'd0, ST_EMPTY, 1'b0));
    add_request(CMD_START, WORD_MAX);
    add_request(CMD_DRAW, 31'd21, 1'b1, result_of(8'd5, ST_PICKED, 1'b1));
    add_request(CMD_DRAW, 31'd0, 1'b1, result_of(8'd0, ST_EMPTY, 1'b0));
    // writes past the register file leave the setting alone
    add_write(REG_SPARE_2, CFG_MAX);
    add_write(REG_SPARE_3, '0);
    // oversized pool saturates before the pick count check
    add_write(REG_POOL_SIZE, CFG_MAX);
    add_write(REG_PICK_COUNT, CFG_MAX);
    add_request(CMD_START, '0, 1'b1, result_of(8'd0, ST_REJECT, 1'b0));
    add_write(REG_PICK_COUNT, 9'd257);
    add_request(CMD_START, '0, 1'b1, result_of(8'd0, ST_REJECT, 1'b0));
    add_write(REG_PICK_COUNT, '0);
    add_request(CMD_START, '0, 1'b1, result_of(8'd0, ST_EMPTY, 1'b0));
    add_write(REG_PICK_COUNT, 9'd1);
    add_request(CMD_START, '0);
    add_request(CMD_DRAW, WORD_MAX, 1'b1, result_of(8'd255, ST_PICKED, 1'b1));
    // empty pool
    add_write(REG_POOL_SIZE, '0);
    add_write(REG_PICK_COUNT, '0);
    add_request(CMD_START, '0, 1'b1, result_of(8'd0, ST_EMPTY, 1'b0));
    add_write(REG_PICK_COUNT, 9'd1);
    add_request(CMD_START, '0, 1'b1, result_of(8'd0, ST_REJECT, 1'b0));
    // pick count raised mid-run: pool runs dry, compacts to nothing, run ends empty
    add_write(REG_POOL_SIZE, 9'd2);
    add_write(REG_PICK_COUNT, 9'd2);
    add_request(CMD_START, '0);
    add_request(CMD_DRAW, 31'd0, 1'b1, result_of(8'd0, ST_PICKED, 1'b0));
    add_write(REG_PICK_COUNT, 9'd5);
    add_request(CMD_DRAW, 31'd1, 1'b1, result_of(8'd1, ST_PICKED, 1'b0));
    add_request(CMD_DRAW, 31'd0);
    add_request(CMD_DRAW, 31'd1);
    add_request(CMD_DRAW, 31'd0);
    add_request(CMD_DRAW, 31'd2, 1'b1, result_of(8'd0, ST_EMPTY, 1'b0));
    // misses trigger a compaction with survivors
    add_write(REG_POOL_SIZE, 9'd3);
    add_write(REG_PICK_COUNT, 9'd3);
    add_request(CMD_START, '0);
    add_request(CMD_DRAW, 31'd1, 1'b1, result_of(8'd1, ST_PICKED, 1'b0));
    add_request(CMD_DRAW, 31'd1);
    add_request(CMD_DRAW, 31'd4);
    add_request(CMD_DRAW, 31'd7);
    add_request(CMD_DRAW, 31'd1);
    add_request(CMD_DRAW, 31'd1);
    add_request(CMD_DRAW, 31'd2);

    cfg_pool_size  = CFG_W'(POOL_SIZE_RESET);
    cfg_pick_count = CFG_W'(PICK_COUNT_RESET);
    for (int i = 0; i < POOL_MAX; i++) begin
      pool_entry[i] = '0;
      entry_free[i] = 1'b0;
    end
    live_count = 0;
    miss_run   = 0;
    picks_made = 0;
    run_open   = 1'b0;

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[k]) begin
      row = script[k];
      if (row.kind == ROW_WRITE) begin
        settle_block();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_request(row.cmd, row.word, 1'b0, row.typed, row.want);
      end
    end

    random_base = requests_sent;
    while (requests_sent - random_base < RANDOM_REQUESTS) random_phase();

    block_dirty = 1'b1;
    settle_block();

    $display("covered %0d requests (%0d starts) and %0d register writes",
             requests_sent, starts_sent, reg_writes);
    $display("results: %0d picks, %0d rejected starts, %0d empty; %0d pool compactions",
             picks_seen, rejects_seen, empties_seen, compactions);
    if (fault_count == 0) begin
      $display("random_sample_without_replacement_tb OK");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("random_sample_without_replacement_tb NOT OK");
    end
    $finish;
  end

endmodule
